// ===== sv/button_press_hold_classifier_defines.svh =====
// assertion macros for the push/hold classifier
// used by button_press_hold_classifier.sv; relies on clk and arst_n at the point of use
`ifndef BUTTON_PRESS_HOLD_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_HOLD_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

`define BPC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpc check failed");

`define BPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bpc check failed");

`else

`define BPC_ASSERT_SAME(label, ante, cons)

`define BPC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/bpc_pkg.sv =====
// shared types and constants of the push/hold classifier
// no dependencies; imported by every module of the block
`default_nettype none

package bpc_pkg;

	localparam int CNT_W       = 6;
	localparam int THR_W       = 6;
	localparam int SAMPLE_BITS = 8;
	localparam int IDX_W       = 3;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	localparam logic [THR_W-1:0] HOLD_THR_RST = 6'd50;
	localparam logic [THR_W-1:0] PUSH_MIN_RST = 6'd2;
	localparam logic [THR_W-1:0] PUSH_MAX_RST = 6'd30;

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_PUSH = 2'd1,
		ST_HOLD = 2'd2
	} sw_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOLD_THRESHOLD = 2'd0,
		REG_PUSH_MIN       = 2'd1,
		REG_PUSH_MAX       = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [THR_W-1:0] hold_threshold;
		logic [THR_W-1:0] push_min;
		logic [THR_W-1:0] push_max;
	} lane_cfg_t;

	typedef struct packed {
		logic tick;
		logic closed;
		logic rd_clr;
	} lane_ctl_t;

endpackage

`default_nettype wire

// ===== sv/bpc_lane.sv =====
// per-switch state and classification: last sample, closed count, reported and recent state
// depends on bpc_pkg
`default_nettype none

module bpc_lane
	import bpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  lane_cfg_t cfg,
	input  lane_ctl_t ctl,
	output sw_state_t reported
);

	logic             prev_q, prev_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
	sw_state_t        rep_q, rep_d, recent_q, recent_d;

	assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);

	always_comb begin
		prev_d   = prev_q;
		cnt_d    = cnt_q;
		rep_d    = rep_q;
		recent_d = recent_q;
		if (ctl.tick) begin
			case ({prev_q, ctl.closed})
				2'b01: begin
					recent_d = ST_NONE;
					prev_d   = 1'b1;
					cnt_d    = cnt_inc;
				end
				2'b11: begin
					if (cnt_inc > cfg.hold_threshold) begin
						rep_d    = ST_HOLD;
						recent_d = ST_HOLD;
						cnt_d    = '0;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				2'b10: begin
					prev_d = 1'b0;
					cnt_d  = '0;
					if (cnt_q >= cfg.push_min && cnt_q <= cfg.push_max &&
					    recent_q == ST_NONE) begin
						rep_d    = ST_PUSH;
						recent_d = ST_PUSH;
					end
				end
				default: begin
					if (recent_q == ST_HOLD || recent_q == ST_PUSH) begin
						rep_d    = ST_NONE;
						recent_d = ST_NONE;
					end
				end
			endcase
		end else if (ctl.rd_clr && rep_q == ST_PUSH) begin
			rep_d    = ST_NONE;
			recent_d = ST_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b0;
			cnt_q    <= '0;
			rep_q    <= ST_NONE;
			recent_q <= ST_NONE;
		end else begin
			prev_q   <= prev_d;
			cnt_q    <= cnt_d;
			rep_q    <= rep_d;
			recent_q <= recent_d;
		end
	end

	assign reported = rep_q;

endmodule

`default_nettype wire

// ===== sv/bpc_merge.sv =====
// merges the lanes for a read: selects the reported state of the addressed switch
// depends on bpc_pkg
`default_nettype none

module bpc_merge
	import bpc_pkg::*;
#(
	parameter int NUM_SWITCHES = 8
) (
	input  sw_state_t        reported [NUM_SWITCHES],
	input  logic [IDX_W-1:0] read_index,
	output sw_state_t        sel_state
);

	always_comb begin
		sel_state = ST_NONE;
		for (int i = 0; i < NUM_SWITCHES; i++) begin
			if (int'(read_index) == i) sel_state = reported[i];
		end
	end

endmodule

`default_nettype wire

// ===== sv/button_press_hold_classifier.sv =====
// channel  dir  signals                        contents
// s        in   s_tvalid s_tready s_tdata      tick or read item, tuser = mode
//                 s_tuser
// m        out  m_tvalid m_tready m_tdata      switch state of a read
// cfg      in   cfg_we cfg_index cfg_data      threshold and push window registers
//
// one item per cycle while s_tready is high; a tick updates every switch lane at its transfer edge
// a read is answered from the lanes in the same cycle and shows on m in the cycle after its transfer
// s_tready drops only while a result waits in the output register and m_tready is low
// reset clears all lane state and loads the register defaults
//
// top level of the push/hold classifier; depends on bpc_pkg, bpc_lane, bpc_merge
// and button_press_hold_classifier_defines.svh
`default_nettype none

`include "button_press_hold_classifier_defines.svh"

module button_press_hold_classifier
	import bpc_pkg::*;
#(
	parameter int NUM_SWITCHES = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // closed_bits[7:0], read_index[10:8], zero fill
	input  logic                 s_tuser,   // mode: 0 tick, 1 read
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // switch_state[1:0], zero fill
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data
);

	lane_cfg_t        cfg_q;
	logic             s_xfer, tick_xfer, rd_xfer;
	logic [SAMPLE_BITS-1:0] closed_bits;
	logic [IDX_W-1:0] read_index;
	sw_state_t        reported [NUM_SWITCHES];
	sw_state_t        sel_state;
	logic             out_valid_q;
	sw_state_t        out_state_q;

	assign closed_bits = s_tdata[SAMPLE_BITS-1:0];
	assign read_index  = s_tdata[SAMPLE_BITS +: IDX_W];

	assign s_tready  = !out_valid_q || m_tready;
	assign s_xfer    = s_tvalid && s_tready;
	assign tick_xfer = s_xfer && !s_tuser;
	assign rd_xfer   = s_xfer && s_tuser;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_threshold <= HOLD_THR_RST;
			cfg_q.push_min       <= PUSH_MIN_RST;
			cfg_q.push_max       <= PUSH_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOLD_THRESHOLD: cfg_q.hold_threshold <= cfg_data;
				REG_PUSH_MIN:       cfg_q.push_min       <= cfg_data;
				REG_PUSH_MAX:       cfg_q.push_max       <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < NUM_SWITCHES; g++) begin : g_lane
		lane_ctl_t ctl;

		always_comb begin
			ctl.tick   = tick_xfer;
			ctl.closed = (g < SAMPLE_BITS) ? closed_bits[g % SAMPLE_BITS] : 1'b0;
			ctl.rd_clr = rd_xfer && (int'(read_index) == g);
		end

		bpc_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg_q),
			.ctl      (ctl),
			.reported (reported[g])
		);
	end

	bpc_merge #(
		.NUM_SWITCHES (NUM_SWITCHES)
	) u_merge (
		.reported   (reported),
		.read_index (read_index),
		.sel_state  (sel_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= rd_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_xfer) begin
			out_state_q <= sel_state;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_state_q};

	`BPC_ASSERT_NEXT(a_read_gives_result, rd_xfer, m_tvalid)
	`BPC_ASSERT_NEXT(a_tick_gives_none, tick_xfer, !m_tvalid)
	`BPC_ASSERT_SAME(a_state_code_valid, m_tvalid, out_state_q != 2'd3)

endmodule

`default_nettype wire
